// File: src/kal_pkg.sv
`timescale 1ns / 1ps

package kal_pkg;

   // Fixed widths of the variance and the noise registers (unsigned Q16.16 style words).
   localparam int VAR_BITS       = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes of the configuration port; any other index is ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEASUREMENT_NOISE = 2'd1;

   // Reset values of the noise registers.
   localparam logic [VAR_BITS-1:0] PROCESS_NOISE_RESET     = 32'd655;
   localparam logic [VAR_BITS-1:0] MEASUREMENT_NOISE_RESET = 32'd6554;

   // Control from the top level to the update engine.
   typedef struct packed {
      logic start;
      logic out_free;
   } kal_ctl_type;

   // Status from the update engine to the top level.
   typedef struct packed {
      logic idle;
      logic done;
   } kal_sts_type;

endpackage

// File: src/kal_if.sv
`timescale 1ns / 1ps

// Sample channel: one beat carries one raw converter word.
interface kal_req_if #(parameter int SAMPLE_BITS = 24);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

// Result channel: one beat carries one filtered estimate.
interface kal_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] filtered_value;

   modport source (output valid, output filtered_value, input ready);
   modport sink (input valid, input filtered_value, output ready);
endinterface

// File: src/kal_alu.sv
`timescale 1ns / 1ps

// Shared adder and subtractor. The sign of a subtraction shows in the top bit
// as long as both operands stay below half the range.
module kal_alu #(
   parameter int WIDTH = 35
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             sub,
   output logic [WIDTH-1:0] result
);

   logic [WIDTH-1:0] b_term;

   // Two's complement subtract by inverting the second operand and adding one.
   assign b_term = op_b ^ {WIDTH{sub}};
   assign result = op_a + b_term + WIDTH'(sub);

endmodule

// File: src/kal_core.sv
`timescale 1ns / 1ps

module kal_core #(
   parameter int SAMPLE_BITS   = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kal_pkg::kal_ctl_type                ctl,
   output kal_pkg::kal_sts_type                sts,
   input  logic [SAMPLE_BITS-1:0]              sample,
   input  logic [kal_pkg::VAR_BITS-1:0]        process_noise,
   input  logic [kal_pkg::VAR_BITS-1:0]        measurement_noise,
   output logic signed [SAMPLE_BITS-1:0]       result
);

   import kal_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int W  = SB + F;
   localparam int VB = VAR_BITS;
   localparam int AW = (W + 2 > VB + 3) ? W + 2 : VB + 3;
   localparam int CW = $clog2(F + 1);
   localparam logic [F:0] GAIN_ONE = {1'b1, {F{1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PADD,
      ST_DEN,
      ST_DIV,
      ST_DIFF,
      ST_ABS,
      ST_MUL1,
      ST_EST,
      ST_CMP,
      ST_MUL2,
      ST_RND
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]    target_ff, target_in;
   logic [W-1:0]    est_ff, est_in;
   logic [VB-1:0]   var_ff, var_in;
   logic [VB-1:0]   p_ff, p_in;
   logic [VB:0]     den_ff, den_in;
   logic [VB+1:0]   rem_ff, rem_in;
   logic [F:0]      gain_ff, gain_in;
   logic [W:0]      tmp_ff, tmp_in;
   logic            neg_ff, neg_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [F:0]      mplier_ff, mplier_in;

   logic [AW-1:0]   alu_a;
   logic [AW-1:0]   alu_b;
   logic            alu_sub;
   logic [AW-1:0]   alu_y;
   logic            qbit;
   logic [VB:0]     rem_keep;
   logic            done;

   kal_alu #(.WIDTH(AW)) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_y)
   );

   // Sequencer: every working step drives the shared adder once.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      target_in = target_ff;
      est_in    = est_ff;
      var_in    = var_ff;
      p_in      = p_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      gain_in   = gain_ff;
      tmp_in    = tmp_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      alu_a     = '0;
      alu_b     = '0;
      alu_sub   = 1'b0;
      qbit      = 1'b0;
      rem_keep  = rem_ff[VB:0];
      done      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // The sample shifted up by the fraction bits is the target in estimate format.
            if (ctl.start) begin
               target_in = {sample, {F{1'b0}}};
               state_in  = ST_PADD;
            end
         end
         ST_PADD: begin
            // Variance plus process noise, saturated at the largest variance.
            alu_a    = AW'(var_ff);
            alu_b    = AW'(process_noise);
            p_in     = alu_y[VB] ? '1 : alu_y[VB-1:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            // Gain denominator; the division starts with the variance as remainder.
            alu_a    = AW'(p_ff);
            alu_b    = AW'(measurement_noise);
            den_in   = alu_y[VB:0];
            rem_in   = {1'b0, 1'b0, p_ff};
            gain_in  = '0;
            cnt_in   = CW'(F);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one gain bit per cycle, integer bit first.
            alu_a    = AW'(rem_ff);
            alu_b    = AW'(den_ff);
            alu_sub  = 1'b1;
            qbit     = !alu_y[AW-1] && (den_ff != '0);
            rem_keep = qbit ? alu_y[VB:0] : rem_ff[VB:0];
            rem_in   = {rem_keep, 1'b0};
            gain_in  = {gain_ff[F-1:0], qbit};
            if (cnt_ff == '0) begin
               state_in = ST_DIFF;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_DIFF: begin
            // Signed distance from the estimate to the sample.
            alu_a    = {{(AW-W){target_ff[W-1]}}, target_ff};
            alu_b    = {{(AW-W){est_ff[W-1]}}, est_ff};
            alu_sub  = 1'b1;
            tmp_in   = alu_y[W:0];
            neg_in   = alu_y[W];
            state_in = ST_ABS;
         end
         ST_ABS: begin
            // Magnitude of the distance; the first multiply is set up.
            alu_a   = '0;
            alu_b   = {{(AW-W-1){tmp_ff[W]}}, tmp_ff};
            alu_sub = 1'b1;
            if (neg_ff) begin
               tmp_in = alu_y[W:0];
            end
            acc_in    = '0;
            mplier_in = gain_ff;
            cnt_in    = CW'(F);
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            // Shift-add multiply of the magnitude by the gain, low bits drop out.
            alu_a     = acc_ff;
            alu_b     = mplier_ff[0] ? AW'(tmp_ff[W-1:0]) : '0;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               acc_in   = alu_y;
               state_in = ST_EST;
            end else begin
               acc_in = alu_y >> 1;
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_EST: begin
            // Move the estimate toward the sample by the truncated step.
            alu_a    = {{(AW-W){est_ff[W-1]}}, est_ff};
            alu_b    = AW'(acc_ff[W-1:0]);
            alu_sub  = neg_ff;
            est_in   = alu_y[W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // One minus the gain is the multiplier for the variance update.
            alu_a     = AW'(GAIN_ONE);
            alu_b     = AW'(gain_ff);
            alu_sub   = 1'b1;
            mplier_in = alu_y[F:0];
            acc_in    = '0;
            cnt_in    = CW'(F);
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            // Shift-add multiply of the variance by one minus the gain.
            alu_a     = acc_ff;
            alu_b     = mplier_ff[0] ? AW'(p_ff) : '0;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               acc_in   = alu_y;
               var_in   = alu_y[VB-1:0];
               state_in = ST_RND;
            end else begin
               acc_in = alu_y >> 1;
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_RND: begin
            // Truncate toward zero: a negative estimate is biased up before the shift.
            alu_a = {{(AW-W){est_ff[W-1]}}, est_ff};
            alu_b = est_ff[W-1] ? AW'({F{1'b1}}) : '0;
            if (ctl.out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result   = alu_y[W-1:F];
   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = done;

   // State, filter state and working registers.
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      target_ff <= target_in;
      p_ff      <= p_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      gain_ff   <= gain_in;
      tmp_ff    <= tmp_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         est_ff   <= '0;
         var_ff   <= VB'(GAIN_ONE);
      end else begin
         state_ff <= state_in;
         est_ff   <= est_in;
         var_ff   <= var_in;
      end
   end

`ifndef SYNTHESIS
   // The division remainder stays below twice the denominator.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && den_ff != '0) |-> (rem_ff < {den_ff, 1'b0}))
      else $error("division remainder out of range");

   // The gain never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ABS) |-> (gain_ff <= GAIN_ONE))
      else $error("gain above one");

   // The step never exceeds the distance to the sample.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EST) |-> (acc_ff <= AW'(tmp_ff[W-1:0])))
      else $error("estimate step passes the sample");

   // A result is only handed over when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (ctl.out_free && state_ff == ST_RND))
      else $error("result handed over without room");
`endif

endmodule

// File: src/adc_sample_kalman_smoother_top.sv
`timescale 1ns / 1ps

// A sample beat is accepted only while the engine is idle, so a new sample waits until the last result is handed over.
// The engine steps are serialised on the shared adder,
// which runs the gain division and both multiplies one bit per cycle.
// A waiting result beat stalls the engine only in its last step.
// Reset: synchronous, active high; estimate 0, variance 1.0, noise registers to defaults.
module adc_sample_kalman_smoother_top #(
   parameter int SAMPLE_BITS   = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   kal_req_if.sink                                req_bus,
   kal_rsp_if.source                              rsp_bus,
   input  logic                                   csr_write_en,
   input  logic [kal_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [kal_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   import kal_pkg::*;

   kal_ctl_type                   ctl;
   kal_sts_type                   sts;
   logic [VAR_BITS-1:0]           q_ff;
   logic [VAR_BITS-1:0]           r_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic signed [SAMPLE_BITS-1:0] core_result;

   // Handshake toward the engine.
   assign req_bus.ready = sts.idle;
   assign ctl.start     = req_bus.valid && sts.idle;
   assign ctl.out_free  = !rsp_valid_ff || rsp_bus.ready;

   kal_core #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .sample            (req_bus.raw_sample),
      .process_noise     (q_ff),
      .measurement_noise (r_ff),
      .result            (core_result)
   );

   // Noise registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= PROCESS_NOISE_RESET;
         r_ff <= MEASUREMENT_NOISE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     q_ff <= csr_write_data[VAR_BITS-1:0];
            CSR_MEASUREMENT_NOISE: r_ff <= csr_write_data[VAR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Output register holds the result beat until it is taken.
   always_ff @(posedge clock) begin
      if (sts.done) begin
         rsp_data_ff <= core_result;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sts.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = rsp_data_ff;

endmodule
